FILE: src/http_request_line_parser_assert.svh
// Assertion macros for the HTTP request-line parser.
// Used by http_request_line_parser.sv; expects clk and rst_n in scope.
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HRLP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRLP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hrlp_pkg.sv
// Shared constants, types and character helpers for the HTTP request-line parser.
// No dependencies; imported by http_request_line_parser.
package hrlp_pkg;

    localparam int URI_COUNT_BITS = 16;
    localparam int LIMIT_W        = 16;
    localparam int CMP_W          = (URI_COUNT_BITS > LIMIT_W) ? URI_COUNT_BITS : LIMIT_W;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2048;

    localparam int METHOD_GET_LEN  = 4;
    localparam int METHOD_HEAD_LEN = 5;
    localparam int PROTO_LEN       = 5;

    typedef enum logic [1:0] {
        VERDICT_OK  = 2'd0,
        VERDICT_400 = 2'd1,
        VERDICT_414 = 2'd2,
        VERDICT_501 = 2'd3
    } verdict_t;

    // Space, tab, LF, VT, FF, CR.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    // Expected byte of "GET " or "HEAD " at a position; zero past the end.
    function automatic logic [7:0] method_char(input logic head, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        if (head)
        begin
            unique case (pos)
                3'd0:    ch = "H";
                3'd1:    ch = "E";
                3'd2:    ch = "A";
                3'd3:    ch = "D";
                3'd4:    ch = " ";
                default: ch = 8'd0;
            endcase
        end
        else
        begin
            unique case (pos)
                3'd0:    ch = "G";
                3'd1:    ch = "E";
                3'd2:    ch = "T";
                3'd3:    ch = " ";
                default: ch = 8'd0;
            endcase
        end
        return ch;
    endfunction

    // Expected byte of "HTTP/" at a position; zero past the end.
    function automatic logic [7:0] proto_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/http_request_line_parser.sv
// HTTP/1.x request-line parser: byte state machine, URI length counter, output register.
// Depends on hrlp_pkg and http_request_line_parser_assert.svh.
//
// Feed the request line one byte per input transfer (char_in), and close each line with a
// transfer that has is_terminator set; that transfer carries no byte and returns the parser
// to method matching. Every input transfer yields exactly one output transfer through the output register:
// uri_char_valid/uri_char pass URI bytes that fit the limit, verdict_valid/verdict flag the
// deciding byte (0 accepted, 1 = 400, 2 = 414, 3 = 501), and method_head tells GET from HEAD.
// The block takes one byte per clock and keeps doing so while the output register is drained
// every cycle; in_ready falls only while a finished result sits unaccepted in the output
// register. Each result is registered in that single output register. The URI limit lives at
// APB byte address 0 (low 16 bits); write it only while no line is in flight.
module http_request_line_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    char_in,
    input  logic                          is_terminator,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          uri_char_valid,
    output logic [7:0]                    uri_char,
    output logic                          verdict_valid,
    output logic [1:0]                    verdict,
    output logic                          method_head,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrlp_pkg::PADDR_W-1:0]  paddr,
    input  logic [hrlp_pkg::PDATA_W-1:0]  pwdata,
    output logic [hrlp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import hrlp_pkg::*;

    typedef enum logic [3:0] {
        PH_METHOD = 4'd0,
        PH_WS1    = 4'd1,
        PH_URI    = 4'd2,
        PH_WS2    = 4'd3,
        PH_PROTO  = 4'd4,
        PH_MAJOR  = 4'd5,
        PH_DOT    = 4'd6,
        PH_MINOR  = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({URI_COUNT_BITS{1'b1}});

    // Parser state
    phase_t                    phase_reg, phase_next;
    logic [2:0]                pos_reg, pos_next;
    logic                      head_reg, head_next;
    logic [URI_COUNT_BITS-1:0] count_reg, count_next;
    logic [LIMIT_W-1:0]        limit_reg;

    // Output register
    logic                      out_valid_reg;
    logic                      uv_reg;
    logic [7:0]                uc_reg;
    logic                      vv_reg;
    verdict_t                  vd_reg;
    logic                      head_out_reg;

    // Per-byte results
    logic                      uv_next;
    logic [7:0]                uc_next;
    logic                      vv_next;
    verdict_t                  vd_next;
    logic                      head_out_next;

    logic                      uri_go;
    logic                      proto_go;
    logic [2:0]                proto_pos;
    logic [CMP_W-1:0]          count_ext;
    logic [CMP_W-1:0]          limit_ext;
    logic [2:0]                method_len;
    logic                      in_fire;
    logic                      cfg_write;
    logic                      verdict_fire;
    logic                      term_fire;
    logic                      parser_clear;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign count_ext      = CMP_W'(count_reg);
    assign limit_ext      = CMP_W'(limit_reg);
    assign method_len     = head_reg ? 3'(METHOD_HEAD_LEN) : 3'(METHOD_GET_LEN);
    // Entering the protocol literal from whitespace starts at its first byte.
    assign proto_pos      = (phase_reg == PH_WS2) ? 3'd0 : pos_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        uv_next       = 1'b0;
        uc_next       = 8'd0;
        vv_next       = 1'b0;
        vd_next       = VERDICT_OK;
        head_out_next = head_reg;
        uri_go        = 1'b0;
        proto_go      = 1'b0;

        if (is_terminator)
        begin
            // Early end before any verdict; then clear for the next line.
            if (phase_reg != PH_DONE)
            begin
                vv_next = 1'b1;
                vd_next = (phase_reg == PH_METHOD) ? VERDICT_501 : VERDICT_400;
            end
            phase_next = PH_METHOD;
            pos_next   = 3'd0;
            head_next  = 1'b0;
            count_next = '0;
        end
        else if (phase_reg != PH_DONE)
        begin
            if (char_in == 8'd0)
            begin
                vv_next = 1'b1;
                vd_next = (phase_reg == PH_METHOD) ? VERDICT_501 : VERDICT_400;
            end
            else
            begin
                unique case (phase_reg)
                    PH_METHOD:
                    begin
                        if (pos_reg == 3'd0)
                        begin
                            if (char_in == "G")
                            begin
                                head_next = 1'b0;
                                pos_next  = 3'd1;
                            end
                            else if (char_in == "H")
                            begin
                                head_next = 1'b1;
                                pos_next  = 3'd1;
                            end
                            else
                            begin
                                vv_next = 1'b1;
                                vd_next = VERDICT_501;
                            end
                        end
                        else if ((pos_reg < method_len) &&
                                 (char_in == method_char(head_reg, pos_reg)))
                        begin
                            if (pos_reg + 3'd1 == method_len)
                            begin
                                phase_next = PH_WS1;
                                pos_next   = 3'd0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            vv_next = 1'b1;
                            vd_next = VERDICT_501;
                        end
                    end
                    PH_WS1:
                    begin
                        if (!is_ws(char_in))
                        begin
                            phase_next = PH_URI;
                            uri_go     = 1'b1;
                        end
                    end
                    PH_URI:
                    begin
                        uri_go = 1'b1;
                    end
                    PH_WS2:
                    begin
                        if (!is_ws(char_in))
                        begin
                            phase_next = PH_PROTO;
                            proto_go   = 1'b1;
                        end
                    end
                    PH_PROTO:
                    begin
                        proto_go = 1'b1;
                    end
                    PH_MAJOR:
                    begin
                        if (!is_ws(char_in))
                        begin
                            if (is_digit(char_in))
                            begin
                                phase_next = PH_DOT;
                            end
                            else
                            begin
                                vv_next = 1'b1;
                                vd_next = VERDICT_400;
                            end
                        end
                    end
                    PH_DOT:
                    begin
                        if (char_in == ".")
                        begin
                            phase_next = PH_MINOR;
                        end
                        else
                        begin
                            vv_next = 1'b1;
                            vd_next = VERDICT_400;
                        end
                    end
                    PH_MINOR:
                    begin
                        if (!is_ws(char_in))
                        begin
                            vv_next = 1'b1;
                            vd_next = is_digit(char_in) ? VERDICT_OK : VERDICT_400;
                        end
                    end
                    default:
                    begin
                        vv_next = 1'b1;
                        vd_next = VERDICT_400;
                    end
                endcase

                if (uri_go)
                begin
                    if (char_in == 8'd32)
                    begin
                        if (count_ext > limit_ext)
                        begin
                            vv_next = 1'b1;
                            vd_next = VERDICT_414;
                        end
                        else
                        begin
                            phase_next = PH_WS2;
                        end
                    end
                    else
                    begin
                        // Saturate at limit+1 or at the counter's full value.
                        if ((count_ext <= limit_ext) && (count_ext < COUNT_MAX))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (CMP_W'(count_next) <= limit_ext)
                        begin
                            uv_next = 1'b1;
                            uc_next = char_in;
                        end
                    end
                end

                if (proto_go)
                begin
                    if ((proto_pos < 3'(PROTO_LEN)) && (char_in == proto_char(proto_pos)))
                    begin
                        if (proto_pos + 3'd1 == 3'(PROTO_LEN))
                        begin
                            phase_next = PH_MAJOR;
                            pos_next   = 3'd0;
                        end
                        else
                        begin
                            pos_next = proto_pos + 3'd1;
                        end
                    end
                    else
                    begin
                        vv_next = 1'b1;
                        vd_next = VERDICT_400;
                    end
                end
            end

            if (vv_next)
            begin
                phase_next = PH_DONE;
            end
            head_out_next = head_next;
        end
    end

    // Control state: parser, limit register, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            pos_reg       <= 3'd0;
            head_reg      <= 1'b0;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (cfg_write && (paddr[2] == 1'b0))
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted byte, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            uv_reg       <= uv_next;
            uc_reg       <= uc_next;
            vv_reg       <= vv_next;
            vd_reg       <= vd_next;
            head_out_reg <= head_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign uri_char_valid = uv_reg;
    assign uri_char       = uc_reg;
    assign verdict_valid  = vv_reg;
    assign verdict        = vd_reg;
    assign method_head    = head_out_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? PDATA_W'(limit_reg) : '0;

    // Terms for the checks below.
    assign verdict_fire = in_fire && !is_terminator && vv_next;
    assign term_fire    = in_fire && is_terminator;
    assign parser_clear = (phase_reg == PH_METHOD) && (count_reg == '0) && (pos_reg == 3'd0);

    `include "http_request_line_parser_assert.svh"

    `HRLP_ASSERT_NOW(a_uri_xor_verdict, out_valid_reg, !(uv_reg && vv_reg), "byte and verdict")
    `HRLP_ASSERT_NOW(a_uri_char_clear, out_valid_reg && !uv_reg, uc_reg == 8'd0, "uri_char set")
    `HRLP_ASSERT_NEXT(a_verdict_locks, verdict_fire, phase_reg == PH_DONE, "parser still active")
    `HRLP_ASSERT_NEXT(a_term_clears, term_fire, parser_clear, "terminator did not clear parser")

endmodule
